[design/qkps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qkps_pkg
// Shared types and constants of the quadrature knob position selector.
// ----------------------------------------------------------------------------
package qkps_pkg;

	localparam int unsigned PosW     = 7;
	localparam int unsigned CodeW    = 2;
	localparam int unsigned AddrW    = 3;
	localparam int unsigned DataW    = 32;
	localparam int unsigned InDataW  = 8;
	localparam int unsigned OutDataW = 16;

	typedef logic [PosW-1:0]  pos_t;
	typedef logic [CodeW-1:0] code_t;

	// pin codes, bit0 = A, bit1 = B
	localparam code_t CodeIdle = 2'd3;
	localparam code_t CodeB    = 2'd2;
	localparam code_t CodeA    = 2'd1;

	localparam pos_t             RingSizeRst  = 7'd24;
	localparam logic [AddrW-1:0] RingSizeAddr = 3'd0;

	// next position for one detent step
	function automatic pos_t step_pos(input pos_t p, input pos_t n, input logic up);
		logic [PosW:0] inc;
		pos_t          r;
		inc = {1'b0, p} + {{PosW{1'b0}}, 1'b1};
		if (n == '0) begin
			r = '0;
		end else if (up) begin
			r = (inc >= {1'b0, n}) ? '0 : inc[PosW-1:0];
		end else if (p == '0) begin
			r = n - {{(PosW-1){1'b0}}, 1'b1};
		end else begin
			r = ((p - {{(PosW-1){1'b0}}, 1'b1}) >= n) ? '0 : (p - {{(PosW-1){1'b0}}, 1'b1});
		end
		return r;
	endfunction

endpackage

[design/qkps_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qkps_cfg
// APB register file: holds ring_size.
// ----------------------------------------------------------------------------
module qkps_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [qkps_pkg::AddrW-1:0] paddr,
	input  logic [qkps_pkg::DataW-1:0] pwdata,
	output logic [qkps_pkg::DataW-1:0] prdata,
	output logic                       pready,
	output qkps_pkg::pos_t             ring_size
);

	qkps_pkg::pos_t ring_size_q;
	logic           wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready && (paddr == qkps_pkg::RingSizeAddr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_size_q <= qkps_pkg::RingSizeRst;
		end else if (wr_en) begin
			ring_size_q <= pwdata[qkps_pkg::PosW-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == qkps_pkg::RingSizeAddr) begin
			prdata = {{(qkps_pkg::DataW-qkps_pkg::PosW){1'b0}}, ring_size_q};
		end
	end

	assign ring_size = ring_size_q;

endmodule

[design/quadrature_knob_position_selector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_knob_position_selector
// Decodes knob A/B samples into a wrapping position plus push-switch events.
// ----------------------------------------------------------------------------
// One result item per input sample, one sample per clock sustained while
// m_tready holds. A sample lands in an input register, one pass of decode
// logic updates the knob state and fills the result register, from which
// m_tvalid is driven. The input register also absorbs one sample while the
// result waits on m_tready. ring_size sits at address 0 of the APB port.
module quadrature_knob_position_selector (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [qkps_pkg::AddrW-1:0]    paddr,
	input  logic [qkps_pkg::DataW-1:0]    pwdata,
	output logic [qkps_pkg::DataW-1:0]    prdata,
	output logic                          pready,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [1:0] ab_code, [2] switch_level, [7:3] zero
	input  logic [qkps_pkg::InDataW-1:0]  s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [6:0] position, [7] stepped, [8] step_up, [9] button_changed,
	// [10] button_pressed, [15:11] zero
	output logic [qkps_pkg::OutDataW-1:0] m_tdata
);

	qkps_pkg::pos_t  ring_size;

	logic            s1_valid_q;
	qkps_pkg::code_t code_s1;
	logic            level_s1;
	logic            advance;

	qkps_pkg::code_t last_code_q;
	logic            parity_q;
	qkps_pkg::pos_t  pos_q;
	logic            last_pressed_q;

	logic            out_valid_q;
	qkps_pkg::pos_t  res_pos_q;
	logic            res_stepped_q;
	logic            res_up_q;
	logic            res_changed_q;
	logic            res_pressed_q;

	logic            down_tr;
	logic            up_tr;
	logic            counted;
	logic            parity_nxt;
	logic            stepped_nxt;
	logic            pressed_nxt;
	qkps_pkg::pos_t  pos_nxt;

	qkps_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.ring_size(ring_size)
	);

	assign advance  = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			code_s1  <= s_tdata[qkps_pkg::CodeW-1:0];
			level_s1 <= s_tdata[qkps_pkg::CodeW];
		end
	end

	// decode
	always_comb begin
		down_tr = ((last_code_q == qkps_pkg::CodeIdle) && (code_s1 == qkps_pkg::CodeB)) ||
		          ((last_code_q == qkps_pkg::CodeA) && (code_s1 == qkps_pkg::CodeIdle));
		up_tr   = ((last_code_q == qkps_pkg::CodeIdle) && (code_s1 == qkps_pkg::CodeA)) ||
		          ((last_code_q == qkps_pkg::CodeB) && (code_s1 == qkps_pkg::CodeIdle));
		counted     = down_tr || up_tr;
		parity_nxt  = parity_q ^ counted;
		stepped_nxt = counted && parity_nxt;
		pos_nxt     = stepped_nxt ? qkps_pkg::step_pos(pos_q, ring_size, up_tr) : pos_q;
		pressed_nxt = !level_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_code_q    <= qkps_pkg::CodeIdle;
			parity_q       <= 1'b0;
			pos_q          <= '0;
			last_pressed_q <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (advance) begin
				last_code_q    <= code_s1;
				parity_q       <= parity_nxt;
				pos_q          <= pos_nxt;
				last_pressed_q <= pressed_nxt;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_pos_q     <= pos_nxt;
			res_stepped_q <= stepped_nxt;
			res_up_q      <= stepped_nxt && up_tr;
			res_changed_q <= pressed_nxt != last_pressed_q;
			res_pressed_q <= pressed_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, res_pressed_q, res_changed_q, res_up_q, res_stepped_q, res_pos_q};

	a_up_needs_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_stepped_q |-> !res_up_q)
		else $error("step_up set without a step");

	a_step_odd_parity: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_stepped_q |-> parity_q)
		else $error("step reported with even parity");

	a_pressed_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (last_pressed_q == res_pressed_q))
		else $error("pressed state out of step with result");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> s1_valid_q && out_valid_q && !m_tready)
		else $error("input stalled without a full pipe");

	a_pos_follows_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (res_pos_q == pos_q))
		else $error("result position differs from state");

endmodule
